>>> design/wstk_pkg.sv
// shared constants, types and codes for the window stack
package wstk_pkg;

  localparam int WINDOWS    = 16;
  localparam int COORD_BITS = 12;
  localparam int ID_BITS    = 8;
  localparam int SLOT_BITS  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int COUNT_BITS = $clog2(WINDOWS + 1);

  // result queue
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ID_BITS-1:0]    win_id_t;
  typedef logic [QCNT_BITS-1:0]  qcnt_t;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLICK = 2'd1;
  localparam logic [1:0] OP_DUMP  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_LOADED = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_HIT    = 3'd2;
  localparam logic [2:0] STAT_MISS   = 3'd3;
  localparam logic [2:0] STAT_ORDER  = 3'd4;
  localparam logic [2:0] STAT_EMPTY  = 3'd5;

  typedef struct packed {
    win_id_t id;
    coord_t  xa;
    coord_t  ya;
    coord_t  xb;
    coord_t  yb;
  } win_rec_t;

  typedef struct packed {
    logic [2:0] status;
    win_id_t    id;
    logic       last;
  } res_t;

  // memory access bundle from the sequencer to the store
  typedef struct packed {
    slot_t    ord_raddr;
    logic     ord_we;
    slot_t    ord_waddr;
    slot_t    ord_wdata;
    slot_t    tab_raddr;
    logic     tab_we;
    slot_t    tab_waddr;
    win_rec_t tab_wdata;
  } mem_req_t;

endpackage

>>> design/wstk_store.sv
// window table and stacking order memories, registered reads
module wstk_store
  import wstk_pkg::*;
(
  input  logic     clk,
  input  mem_req_t mreq,
  output slot_t    ord_rdata,
  output win_rec_t tab_rdata
);

  slot_t    ord_mem [WINDOWS];
  win_rec_t tab_mem [WINDOWS];

  always_ff @(posedge clk) begin
    if (mreq.ord_we) begin
      ord_mem[mreq.ord_waddr] <= mreq.ord_wdata;
    end
    ord_rdata <= ord_mem[mreq.ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (mreq.tab_we) begin
      tab_mem[mreq.tab_waddr] <= mreq.tab_wdata;
    end
    tab_rdata <= tab_mem[mreq.tab_raddr];
  end

endmodule

>>> design/wstk_outq.sv
// small result queue between the sequencer and the response port
module wstk_outq
  import wstk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  output qcnt_t qcnt,
  output logic rsp_valid,
  input  logic rsp_stall,
  output res_t head
);

  res_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wp;
  logic [QPTR_BITS-1:0] rp;
  logic                 pop;

  assign rsp_valid = (qcnt != '0);
  assign pop       = rsp_valid && !rsp_stall;
  assign head      = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      qcnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   qcnt <= qcnt + 1'b1;
        2'b01:   qcnt <= qcnt - 1'b1;
        default: qcnt <= qcnt;
      endcase
    end
  end

endmodule

>>> design/wstk_ctrl.sv
// request sequencer: load, scan pipeline, move-to-front shift
module wstk_ctrl
  import wstk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] op,
  input  win_id_t    win_id,
  input  coord_t     ax,
  input  coord_t     ay,
  input  coord_t     bx,
  input  coord_t     by,
  output mem_req_t   mreq,
  input  slot_t      ord_rdata,
  input  win_rec_t   tab_rdata,
  input  qcnt_t      qcnt,
  output logic       push,
  output res_t       push_res
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

  state_t state;
  count_t count;
  logic   is_dump;
  coord_t px;
  coord_t py;
  count_t rd_pos;
  logic   s1_v;
  count_t s1_pos;
  logic   s2_v;
  count_t s2_pos;
  slot_t  s2_slot;
  slot_t  hit_slot;
  slot_t  sh_q;
  slot_t  sh_wq;
  logic   sh_pend;

  logic                 accept;
  logic                 full;
  logic [QCNT_BITS:0]   committed;
  logic                 credit;
  coord_t               xlo, xhi, ylo, yhi;
  logic                 in_rect;
  logic                 last_pos;
  logic                 hit_now;
  logic                 issue;

  assign req_stall = !((state == ST_IDLE) && (qcnt < qcnt_t'(QDEPTH)));
  assign accept    = req_valid && !req_stall;
  assign full      = (count >= count_t'(WINDOWS));

  // results already queued or still in the read pipeline
  assign committed = {1'b0, qcnt} + (QCNT_BITS+1)'(s1_v) + (QCNT_BITS+1)'(s2_v);
  assign credit    = committed < (QCNT_BITS+1)'(QDEPTH);

  // normalized inclusive rectangle test
  assign xlo     = (tab_rdata.xa < tab_rdata.xb) ? tab_rdata.xa : tab_rdata.xb;
  assign xhi     = (tab_rdata.xa < tab_rdata.xb) ? tab_rdata.xb : tab_rdata.xa;
  assign ylo     = (tab_rdata.ya < tab_rdata.yb) ? tab_rdata.ya : tab_rdata.yb;
  assign yhi     = (tab_rdata.ya < tab_rdata.yb) ? tab_rdata.yb : tab_rdata.ya;
  assign in_rect = (px >= xlo) && (px <= xhi) && (py >= ylo) && (py <= yhi);

  assign last_pos = ((s2_pos + 1'b1) == count);
  assign hit_now  = (state == ST_SCAN) && !is_dump && s2_v && in_rect;
  assign issue    = (state == ST_SCAN) && (rd_pos < count) && !hit_now &&
                    (!is_dump || credit);

  // memory ports
  always_comb begin
    mreq           = '0;
    mreq.ord_raddr = (state == ST_SHIFT) ? slot_t'(sh_q - 1'b1)
                                         : rd_pos[SLOT_BITS-1:0];
    mreq.tab_raddr = ord_rdata;
    if (state == ST_IDLE) begin
      if (accept && (op == OP_LOAD) && !full) begin
        mreq.ord_we         = 1'b1;
        mreq.ord_waddr      = count[SLOT_BITS-1:0];
        mreq.ord_wdata      = count[SLOT_BITS-1:0];
        mreq.tab_we         = 1'b1;
        mreq.tab_waddr      = count[SLOT_BITS-1:0];
        mreq.tab_wdata.id   = win_id;
        mreq.tab_wdata.xa   = ax;
        mreq.tab_wdata.ya   = ay;
        mreq.tab_wdata.xb   = bx;
        mreq.tab_wdata.yb   = by;
      end
    end else if (state == ST_SHIFT) begin
      if (sh_pend) begin
        mreq.ord_we    = 1'b1;
        mreq.ord_waddr = sh_wq;
        mreq.ord_wdata = ord_rdata;
      end else if (sh_q == '0) begin
        mreq.ord_we    = 1'b1;
        mreq.ord_waddr = '0;
        mreq.ord_wdata = hit_slot;
      end
    end
  end

  // result generation
  always_comb begin
    push            = 1'b0;
    push_res.status = STAT_LOADED;
    push_res.id     = '0;
    push_res.last   = 1'b1;
    if (state == ST_IDLE && accept) begin
      unique case (op)
        OP_LOAD: begin
          push            = 1'b1;
          push_res.status = full ? STAT_FULL : STAT_LOADED;
          push_res.id     = win_id;
        end
        OP_CLICK: begin
          push            = (count == '0);
          push_res.status = STAT_MISS;
        end
        OP_DUMP: begin
          push            = (count == '0);
          push_res.status = STAT_EMPTY;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end else if (state == ST_SCAN && s2_v) begin
      if (is_dump) begin
        push            = 1'b1;
        push_res.status = STAT_ORDER;
        push_res.id     = tab_rdata.id;
        push_res.last   = last_pos;
      end else if (in_rect) begin
        push            = 1'b1;
        push_res.status = STAT_HIT;
        push_res.id     = tab_rdata.id;
      end else if (last_pos) begin
        push            = 1'b1;
        push_res.status = STAT_MISS;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px      <= ax;
      py      <= ay;
      is_dump <= (op == OP_DUMP);
    end
    s1_pos  <= rd_pos;
    s2_pos  <= s1_pos;
    s2_slot <= ord_rdata;
    if (hit_now) begin
      hit_slot <= s2_slot;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_pos  <= '0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      sh_q    <= '0;
      sh_wq   <= '0;
      sh_pend <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          rd_pos <= '0;
          s1_v   <= 1'b0;
          s2_v   <= 1'b0;
          if (accept) begin
            if ((op == OP_LOAD) && !full) begin
              count <= count + 1'b1;
            end
            if (((op == OP_CLICK) || (op == OP_DUMP)) && (count != '0)) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          s1_v <= issue;
          s2_v <= s1_v && !hit_now;
          if (issue) begin
            rd_pos <= rd_pos + 1'b1;
          end
          if (hit_now) begin
            sh_q    <= s2_pos[SLOT_BITS-1:0];
            sh_pend <= 1'b0;
            state   <= ST_SHIFT;
          end else if (s2_v && last_pos) begin
            state <= ST_IDLE;
          end
        end
        ST_SHIFT: begin
          if (sh_q != '0) begin
            sh_pend <= 1'b1;
            sh_wq   <= sh_q;
            sh_q    <= slot_t'(sh_q - 1'b1);
          end else if (sh_pend) begin
            sh_pend <= 1'b0;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/window_stack_click_to_front.sv
// top level of the window stack with click-to-front
//
// Keeps a stacking order of up to WINDOWS rectangles (wstk_pkg) in two
// synchronous memories with registered reads: a window table of id and
// corners per slot, and a stacking order of slot numbers, top first. A
// load request appends a window at the bottom and answers loaded, or full
// with the id when WINDOWS are already stored. A click request reads the
// stack through a read pipeline (order memory, then table memory, then the
// normalized inclusive rectangle test), one stack position per cycle. A
// hit at stack position p answers hit with the id and then moves the
// window to the top by rewriting the order memory one entry per cycle.
// A dump request streams the n ids top to bottom, last set on the final
// one, or answers empty when nothing is loaded. Requests are taken one at
// a time: req_stall stays high until the sequencer is back in idle and the
// four-entry response queue has room, so a waiting response holds off the
// next request only when the queue is full. Op code 3 is taken and gives
// no response. There is no clearing pass after reset; the memories keep
// their contents and only the window count, the sequencer state and the
// response queue are cleared.
module window_stack_click_to_front
  import wstk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  win_id,
  input  logic [11:0] corner_ax,
  input  logic [11:0] corner_ay,
  input  logic [11:0] corner_bx,
  input  logic [11:0] corner_by,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [7:0]  out_id,
  output logic        last
);

  mem_req_t mreq;
  slot_t    ord_rdata;
  win_rec_t tab_rdata;
  qcnt_t    qcnt;
  logic     push;
  res_t     push_res;
  res_t     head;

  // sequencer: owns the window count and both memory ports
  wstk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .win_id    (win_id),
    .ax        (corner_ax[COORD_BITS-1:0]),
    .ay        (corner_ay[COORD_BITS-1:0]),
    .bx        (corner_bx[COORD_BITS-1:0]),
    .by        (corner_by[COORD_BITS-1:0]),
    .mreq      (mreq),
    .ord_rdata (ord_rdata),
    .tab_rdata (tab_rdata),
    .qcnt      (qcnt),
    .push      (push),
    .push_res  (push_res)
  );

  // window table and stacking order
  wstk_store u_store (
    .clk       (clk),
    .mreq      (mreq),
    .ord_rdata (ord_rdata),
    .tab_rdata (tab_rdata)
  );

  // response queue; dump reads are issued only against free entries
  wstk_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .qcnt      (qcnt),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .head      (head)
  );

  assign status = head.status;
  assign out_id = head.id;
  assign last   = head.last;

endmodule

>>> design/wstk_chk.sv
// port-level checks for the window stack, bound to the top level
module wstk_chk
  import wstk_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [2:0] status,
  input logic [7:0] out_id,
  input logic       last
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
    $stable(out_id) && $stable(last))
    else $error("stalled response changed");

  // nothing pending right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // only order entries can be followed by more responses of the same request
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != STAT_ORDER) |-> last)
    else $error("single response without last");

  // miss and empty carry no id
  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((status == STAT_MISS) || (status == STAT_EMPTY)) |-> (out_id == '0))
    else $error("miss or empty with nonzero id");

endmodule

bind window_stack_click_to_front wstk_chk u_wstk_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .status    (status),
  .out_id    (out_id),
  .last      (last)
);

>>> tb/window_stack_checker.sv
// response checker for the window stack: tracks the stack and compares every response
module window_stack_checker
  import wstk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_stall,
  input  logic [1:0] op,
  input  win_id_t    win_id,
  input  coord_t     corner_ax,
  input  coord_t     corner_ay,
  input  coord_t     corner_bx,
  input  coord_t     corner_by,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  logic [2:0] status,
  input  win_id_t    out_id,
  input  logic       last,
  output int         mismatches,
  output int         pending,
  output int         checked
);

  win_rec_t shadow_tab[WINDOWS];
  slot_t    shadow_order[WINDOWS];
  int       shadow_count;
  res_t     due_rsp[$];

  // inclusive test against the normalized rectangle
  function automatic logic covers(win_rec_t w, coord_t x, coord_t y);
    coord_t lx, hx, ly, hy;
    lx = (w.xa < w.xb) ? w.xa : w.xb;
    hx = (w.xa < w.xb) ? w.xb : w.xa;
    ly = (w.ya < w.yb) ? w.ya : w.yb;
    hy = (w.ya < w.yb) ? w.yb : w.ya;
    return (x >= lx) && (x <= hx) && (y >= ly) && (y <= hy);
  endfunction

  function automatic void note_failure(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  // update the stack image for one request and queue the responses it causes
  task automatic apply_request(input logic [1:0] code, input win_id_t id,
                               input coord_t ax, input coord_t ay,
                               input coord_t bx, input coord_t by);
    int    hit_pos;
    slot_t s;
    hit_pos = -1;
    case (code)
      OP_LOAD: begin
        if (shadow_count >= WINDOWS) begin
          due_rsp.push_back(res_t'{STAT_FULL, id, 1'b1});
        end else begin
          shadow_tab[shadow_count]   = win_rec_t'{id, ax, ay, bx, by};
          shadow_order[shadow_count] = slot_t'(shadow_count);
          shadow_count++;
          due_rsp.push_back(res_t'{STAT_LOADED, id, 1'b1});
        end
      end
      OP_CLICK: begin
        for (int p = 0; p < shadow_count && hit_pos < 0; p++) begin
          if (covers(shadow_tab[shadow_order[p]], ax, ay)) hit_pos = p;
        end
        if (hit_pos < 0) begin
          due_rsp.push_back(res_t'{STAT_MISS, win_id_t'(0), 1'b1});
        end else begin
          s = shadow_order[hit_pos];
          for (int q = hit_pos; q > 0; q--) shadow_order[q] = shadow_order[q-1];
          shadow_order[0] = s;
          due_rsp.push_back(res_t'{STAT_HIT, shadow_tab[s].id, 1'b1});
        end
      end
      OP_DUMP: begin
        if (shadow_count == 0) begin
          due_rsp.push_back(res_t'{STAT_EMPTY, win_id_t'(0), 1'b1});
        end else begin
          for (int p = 0; p < shadow_count; p++) begin
            due_rsp.push_back(res_t'{STAT_ORDER, shadow_tab[shadow_order[p]].id,
                                     logic'(p == shadow_count - 1)});
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      shadow_count = 0;
      due_rsp.delete();
    end else begin
      // responses first: a request taken at this edge cannot answer at it
      if (rsp_valid && !rsp_stall) begin
        checked++;
        if (due_rsp.size() == 0) begin
          note_failure($sformatf("unexpected response status %0d id %0h last %0b",
                                 status, out_id, last));
        end else begin
          want = due_rsp.pop_front();
          if (status !== want.status || out_id !== want.id || last !== want.last) begin
            note_failure($sformatf(
              "expected status %0d id %0h last %0b, got status %0d id %0h last %0b",
              want.status, want.id, want.last, status, out_id, last));
          end
        end
      end
      if (req_valid && !req_stall) begin
        apply_request(op, win_id, corner_ax, corner_ay, corner_bx, corner_by);
      end
    end
    pending = due_rsp.size();
  end

endmodule

>>> tb/window_stack_click_to_front_tb.sv
// testbench top for the window stack: stimulus, stall patterns, watchdog and verdict
module window_stack_click_to_front_tb;
  import wstk_pkg::*;

  // cycles with no handshake on either channel before giving up
  localparam int LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic [1:0] op;
  win_id_t    win_id;
  coord_t     corner_ax, corner_ay, corner_bx, corner_by;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [2:0] status;
  win_id_t    out_id;
  logic       last;

  int mismatches, pending, checked;

  // idle percentages of the current phase
  int send_idle_pct;
  int take_stall_pct;

  // stimulus bookkeeping: request counts per op and the rectangles stored
  // so far, kept only so clicks can be aimed at windows
  int     n_load, n_click, n_dump, n_unused;
  int     stored_n;
  coord_t rect_lx[WINDOWS], rect_hx[WINDOWS], rect_ly[WINDOWS], rect_hy[WINDOWS];

  int idle_cycles;

  window_stack_click_to_front i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .win_id    (win_id),
    .corner_ax (corner_ax),
    .corner_ay (corner_ay),
    .corner_bx (corner_bx),
    .corner_by (corner_by),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .out_id    (out_id),
    .last      (last)
  );

  window_stack_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .op         (op),
    .win_id     (win_id),
    .corner_ax  (corner_ax),
    .corner_ay  (corner_ay),
    .corner_bx  (corner_bx),
    .corner_by  (corner_by),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .out_id     (out_id),
    .last       (last),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < take_stall_pct);
  end

  // watchdog: a long stretch with no request and no response taken means a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                 LIMIT, pending);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one request: optional sender gap, then hold the payload until taken;
  // entered and left just after a falling edge
  task automatic send_request(input logic [1:0] code, input win_id_t id,
                              input coord_t ax, input coord_t ay,
                              input coord_t bx, input coord_t by);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    op        = code;
    win_id    = id;
    corner_ax = ax;
    corner_ay = ay;
    corner_bx = bx;
    corner_by = by;
    req_valid = 1'b1;
    case (code)
      OP_LOAD: begin
        n_load++;
        // remember stored rectangles, normalized, for aiming clicks
        if (stored_n < WINDOWS) begin
          rect_lx[stored_n] = (ax < bx) ? ax : bx;
          rect_hx[stored_n] = (ax < bx) ? bx : ax;
          rect_ly[stored_n] = (ay < by) ? ay : by;
          rect_hy[stored_n] = (ay < by) ? by : ay;
          stored_n++;
        end
      end
      OP_CLICK: n_click++;
      OP_DUMP:  n_dump++;
      default:  n_unused++;
    endcase
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // mix of screen-sized rectangles (lots of overlap, deep scans) and small
  // ones; corners come in either order so normalization is exercised
  task automatic random_load();
    coord_t ax, ay, bx, by, t;
    ax = coord_t'($urandom);
    ay = coord_t'($urandom);
    if ($urandom_range(1)) begin
      bx = coord_t'($urandom);
      by = coord_t'($urandom);
    end else begin
      bx = ax + coord_t'($urandom_range(400));
      by = ay + coord_t'($urandom_range(400));
      if ($urandom_range(1)) begin
        t = ax; ax = bx; bx = t;
      end
      if ($urandom_range(1)) begin
        t = ay; ay = by; by = t;
      end
    end
    send_request(OP_LOAD, win_id_t'($urandom), ax, ay, bx, by);
  endtask

  // clicks mostly inside a stored window, some right on its border, some
  // just outside it, and some anywhere on the screen
  task automatic random_click();
    coord_t x, y;
    int     k, mode;
    mode = $urandom_range(99);
    if (stored_n == 0 || mode < 15) begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
    end else begin
      k = $urandom_range(stored_n - 1);
      x = rect_lx[k] + coord_t'($urandom_range(rect_hx[k] - rect_lx[k]));
      y = rect_ly[k] + coord_t'($urandom_range(rect_hy[k] - rect_ly[k]));
      if (mode >= 60 && mode < 80) begin
        x = $urandom_range(1) ? rect_lx[k] : rect_hx[k];
        y = $urandom_range(1) ? rect_ly[k] : rect_hy[k];
      end else if (mode >= 80) begin
        x = (rect_lx[k] == 0) ? rect_hx[k] + 1'b1 : rect_lx[k] - 1'b1;
      end
    end
    send_request(OP_CLICK, win_id_t'($urandom), x, y,
                 coord_t'($urandom), coord_t'($urandom));
  endtask

  initial begin
    int issued, pick;
    rst       = 1'b1;
    req_valid = 1'b0;
    op        = OP_NONE;
    win_id    = '0;
    corner_ax = '0;
    corner_ay = '0;
    corner_bx = '0;
    corner_by = '0;
    // first phase: sender idles lightly, receiver stalls heavily
    send_idle_pct  = 24;
    take_stall_pct = 65;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty stack: dump reports empty, click misses, unused op is dropped
    send_request(OP_DUMP,  8'h00, 12'd0, 12'd0, 12'd0, 12'd0);
    send_request(OP_CLICK, 8'h00, 12'd0, 12'd0, 12'd0, 12'd0);
    send_request(OP_NONE,  8'h00, 12'd0, 12'd0, 12'd0, 12'd0);
    // four windows, corners given in swapped order on some, coordinate extremes
    send_request(OP_LOAD, 8'h01, 12'd100,  12'd200,  12'd50,   12'd150);
    send_request(OP_LOAD, 8'h80, 12'd60,   12'd160,  12'd300,  12'd400);
    send_request(OP_LOAD, 8'hFF, 12'd4095, 12'd4095, 12'd4000, 12'd4000);
    send_request(OP_LOAD, 8'h00, 12'd0,    12'd0,    12'd10,   12'd10);
    send_request(OP_DUMP, 8'h00, 12'd0, 12'd0, 12'd0, 12'd0);
    // hits on inclusive corners of the top window
    send_request(OP_CLICK, 8'h00, 12'd50,  12'd150, 12'd0, 12'd0);
    send_request(OP_CLICK, 8'h00, 12'd100, 12'd200, 12'd0, 12'd0);
    // one past the edge of the top window lands in the second, which moves up
    send_request(OP_CLICK, 8'h00, 12'd101, 12'd200, 12'd0, 12'd0);
    // bottom windows at the screen corners move to the top
    send_request(OP_CLICK, 8'h00, 12'd0,    12'd0,    12'd0, 12'd0);
    send_request(OP_CLICK, 8'h00, 12'd4095, 12'd4095, 12'd0, 12'd0);
    // misses: empty corner of the screen and just left of a window
    send_request(OP_CLICK, 8'h00, 12'd0,  12'd4095, 12'd0, 12'd0);
    send_request(OP_CLICK, 8'h00, 12'd49, 12'd150,  12'd0, 12'd0);
    // overlap of two windows: the higher one wins
    send_request(OP_CLICK, 8'h00, 12'd75, 12'd175, 12'd0, 12'd0);
    send_request(OP_DUMP, 8'h00, 12'd0, 12'd0, 12'd0, 12'd0);
    send_request(OP_NONE, 8'hFF, 12'd4095, 12'd4095, 12'd4095, 12'd4095);

    // random part: the stack fills up along the way, after which loads are
    // rejected while clicks keep reshuffling a full stack
    issued = 0;
    while (issued < 150) begin
      if (issued == 50) begin
        send_idle_pct  = 65;
        take_stall_pct = 24;
      end else if (issued == 100) begin
        send_idle_pct  = 0;
        take_stall_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_request(OP_NONE, win_id_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      end else begin
        issued++;
        if (pick < 34) begin
          random_load();
        end else if (pick < 84) begin
          random_click();
        end else begin
          send_request(OP_DUMP, win_id_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        end
      end
    end
    req_valid = 1'b0;

    // drain, then give a click reorder time to settle
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d loads (%0d stored), %0d clicks, %0d dumps, %0d unused-op requests",
             n_load, stored_n, n_click, n_dump, n_unused);
    $display("%0d responses checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
